// ===== design/sgs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Sobel gradient stream.
// No dependencies; imported by every module of the block.
package sgs_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 12;
  localparam int GRAD_W     = 11;
  localparam int POS_W      = 11;
  localparam int OUT_DATA_W = 48;
  localparam int SIZE_FLOOR = 3;
  localparam int RESET_SIZE = 1024;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } sgs_cmd_t;

  typedef logic [PIX_W-1:0] sgs_pix_t;

  // One window column: [0] top, [1] middle, [2] bottom.
  typedef sgs_pix_t [2:0] sgs_col_t;

  // 3x3 window: [0] left, [1] centre, [2] right column.
  typedef sgs_col_t [2:0] sgs_win_t;

  // One line buffer entry: the two rows above the current one.
  typedef struct packed {
    sgs_pix_t newer;
    sgs_pix_t older;
  } sgs_line_t;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             left_edge;
    logic             right_edge;
    logic             top_edge;
    logic             bottom_edge;
    logic             last;
  } sgs_meta_t;

endpackage

// ===== design/sgs_line_buffer.sv =====
`timescale 1ns / 1ps
// Line buffer memory: one entry per column holding the two previous rows.
// Depends on sgs_pkg for the entry type.
module sgs_line_buffer #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  sgs_pkg::sgs_line_t       wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output sgs_pkg::sgs_line_t       rd_data
);
  import sgs_pkg::*;

  sgs_line_t mem [DEPTH];
  sgs_line_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sgs_window_ctrl.sv =====
`timescale 1ns / 1ps
// Position counters, line buffer access, 3x3 window and the window stage
// register. Depends on sgs_pkg and sgs_line_buffer.
module sgs_window_ctrl #(
  parameter int MAX_SIZE = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [sgs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sgs_pkg::sgs_cmd_t             in_cmd,
  input  sgs_pkg::sgs_pix_t             in_height,
  output logic                          a_valid,
  input  logic                          a_ready,
  output sgs_pkg::sgs_win_t             a_win,
  output sgs_pkg::sgs_meta_t            a_meta
);
  import sgs_pkg::*;

  localparam int AW      = $clog2(MAX_SIZE);
  localparam int SW      = AW + 1;
  localparam int RESET_N = (MAX_SIZE < RESET_SIZE) ? MAX_SIZE : RESET_SIZE;

  logic [SW-1:0] n_r, n_nxt;
  logic [AW-1:0] nm1_r, nm1_nxt;
  logic [SW-1:0] in_col_r, in_col_nxt;
  logic [SW-1:0] in_row_r, in_row_nxt;
  logic [AW-1:0] ocol_r, ocol_nxt;
  logic [AW-1:0] orow_r, orow_nxt;
  sgs_win_t      win_r, win_nxt;
  logic          a_valid_r, a_valid_nxt;
  sgs_win_t      a_win_r, a_win_nxt;
  sgs_meta_t     a_meta_r, a_meta_nxt;

  logic          in_fire;
  logic          in_phase;
  logic          is_flush;
  logic          last_pos;
  logic          col_end;
  logic          do_shift;
  logic          emit;
  logic          restart;
  logic          wr_en;
  logic [SW-1:0] cfg_n;
  sgs_line_t     rd_data;
  sgs_line_t     wr_data;
  sgs_col_t      shift_col;
  sgs_win_t      win_shift;

  assign in_ready = !a_valid_r || a_ready;
  assign in_fire  = in_valid && in_ready;
  assign in_phase = in_row_r < n_r;
  assign is_flush = (in_cmd == CMD_FLUSH);
  assign last_pos = (ocol_r == nm1_r) && (orow_r == nm1_r);
  assign col_end  = (in_col_r == {1'b0, nm1_r});

  assign do_shift = in_fire && (!in_phase || !is_flush);
  assign emit     = in_fire && (!in_phase ||
                    (!is_flush && ((in_row_r > SW'(1)) ||
                                   ((in_row_r == SW'(1)) && (in_col_r != '0)))));
  assign restart  = in_fire && !in_phase && last_pos;
  assign wr_en    = in_fire && in_phase && !is_flush;

  // Rotate the previous row down one slot and store the new pixel.
  assign wr_data.older = rd_data.newer;
  assign wr_data.newer = in_height;

  always_comb begin
    if (32'(cfg_data) > MAX_SIZE) begin
      cfg_n = SW'(MAX_SIZE);
    end else if (32'(cfg_data) < SIZE_FLOOR) begin
      cfg_n = SW'(SIZE_FLOOR);
    end else begin
      cfg_n = SW'(cfg_data);
    end
  end

  // New right column: while draining, the bottom row is empty.
  always_comb begin
    shift_col = '0;
    if (in_phase) begin
      shift_col[0] = rd_data.older;
      shift_col[1] = rd_data.newer;
      shift_col[2] = in_height;
    end else if (in_col_r < n_r) begin
      shift_col[0] = rd_data.older;
      shift_col[1] = rd_data.newer;
    end
    win_shift    = '0;
    win_shift[0] = win_r[1];
    win_shift[1] = win_r[2];
    win_shift[2] = shift_col;
  end

  always_comb begin
    n_nxt      = n_r;
    nm1_nxt    = nm1_r;
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    win_nxt    = win_r;
    if (cfg_valid) begin
      n_nxt      = cfg_n;
      nm1_nxt    = AW'(cfg_n - SW'(1));
      in_col_nxt = '0;
      in_row_nxt = '0;
      ocol_nxt   = '0;
      orow_nxt   = '0;
      win_nxt    = '0;
    end else begin
      if (do_shift) begin
        win_nxt = win_shift;
      end
      if (wr_en) begin
        if (col_end) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + SW'(1);
        end else begin
          in_col_nxt = in_col_r + SW'(1);
        end
      end else if (in_fire && !in_phase) begin
        in_col_nxt = in_col_r + SW'(1);
      end
      if (emit) begin
        if (ocol_r == nm1_r) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + AW'(1);
        end else begin
          ocol_nxt = ocol_r + AW'(1);
        end
      end
      // Frame done: start over for the next image.
      if (restart) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        ocol_nxt   = '0;
        orow_nxt   = '0;
        win_nxt    = '0;
      end
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_win_nxt   = a_win_r;
    a_meta_nxt  = a_meta_r;
    if (emit) begin
      a_valid_nxt            = 1'b1;
      a_win_nxt              = win_shift;
      a_meta_nxt.column      = POS_W'(ocol_r);
      a_meta_nxt.row         = POS_W'(orow_r);
      a_meta_nxt.left_edge   = (ocol_r == '0);
      a_meta_nxt.right_edge  = (ocol_r == nm1_r);
      a_meta_nxt.top_edge    = (orow_r == '0);
      a_meta_nxt.bottom_edge = (orow_r == nm1_r);
      a_meta_nxt.last        = last_pos;
    end else if (a_ready) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= SW'(RESET_N);
      nm1_r     <= AW'(RESET_N - 1);
      in_col_r  <= '0;
      in_row_r  <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
      win_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      n_r       <= n_nxt;
      nm1_r     <= nm1_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      ocol_r    <= ocol_nxt;
      orow_r    <= orow_nxt;
      win_r     <= win_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_win_r  <= a_win_nxt;
    a_meta_r <= a_meta_nxt;
  end

  // Read ahead: fetch the entry of the column the next item will use.
  sgs_line_buffer #(
    .DEPTH (MAX_SIZE)
  ) u_line_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_col_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (in_col_nxt[AW-1:0]),
    .rd_data (rd_data)
  );

  assign a_valid = a_valid_r;
  assign a_win   = a_win_r;
  assign a_meta  = a_meta_r;

`ifndef SYNTHESIS
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= n_r)
    else $error("input row ran past the image size");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_row_r < n_r) |-> (in_col_r < n_r))
    else $error("input column out of range while taking pixels");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (in_row_r == '0 && in_col_r == '0 && ocol_r == '0 && orow_r == '0))
    else $error("frame did not restart after its last result");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !a_ready) |=> (a_valid_r && $stable(a_meta_r) && $stable(a_win_r)))
    else $error("window stage changed while stalled");
`endif

endmodule

// ===== design/sgs_gradient.sv =====
`timescale 1ns / 1ps
// Border replacement, Sobel sums and the result register.
// Depends on sgs_pkg for the window and position types.
module sgs_gradient (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             a_valid,
  output logic                             a_ready,
  input  sgs_pkg::sgs_win_t                a_win,
  input  sgs_pkg::sgs_meta_t               a_meta,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sgs_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                             out_last
);
  import sgs_pkg::*;

  localparam int SUM_W = PIX_W + 2;

  logic                         out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]        out_data_r, out_data_nxt;
  logic                         out_last_r, out_last_nxt;

  sgs_win_t                     k;
  logic [SUM_W-1:0]             left_sum, right_sum, top_sum, bottom_sum;
  logic signed [SUM_W+1:0]      gx_full, gy_full;
  logic [GRAD_W-1:0]            gx, gy;

  function automatic logic [SUM_W-1:0] wsum(sgs_pix_t a, sgs_pix_t b, sgs_pix_t c);
    wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  // Missing neighbors at the borders take the centre column or row.
  always_comb begin
    k = a_win;
    if (a_meta.left_edge) begin
      k[0] = k[1];
    end
    if (a_meta.right_edge) begin
      k[2] = k[1];
    end
    for (int c = 0; c < 3; c++) begin
      if (a_meta.top_edge) begin
        k[c][0] = k[c][1];
      end
      if (a_meta.bottom_edge) begin
        k[c][2] = k[c][1];
      end
    end
  end

  assign left_sum   = wsum(k[0][0], k[0][1], k[0][2]);
  assign right_sum  = wsum(k[2][0], k[2][1], k[2][2]);
  assign top_sum    = wsum(k[0][0], k[1][0], k[2][0]);
  assign bottom_sum = wsum(k[0][2], k[1][2], k[2][2]);

  assign gx_full = $signed({2'b00, left_sum}) - $signed({2'b00, right_sum});
  assign gy_full = $signed({2'b00, top_sum}) - $signed({2'b00, bottom_sum});
  assign gx      = gx_full[GRAD_W-1:0];
  assign gy      = gy_full[GRAD_W-1:0];

  assign a_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (a_valid && a_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_DATA_W'({a_meta.row, a_meta.column, gy, gx});
      out_last_nxt  = a_meta.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/sobel_gradient_stream.sv =====
`timescale 1ns / 1ps
// Streaming 3x3 Sobel gradient over a square image. Throughput: one item per cycle
// while the result side does not stall. When the item that completes a window (one
// row and one column later) is accepted, the window goes to the window stage, then
// its result to the result register. Line buffer reads are fetched ahead of the item that uses them.
// Reset (rst_n, synchronous, active low): size 1024 (MAX_SIZE if smaller), counters and
// window cleared; the line buffer is not cleared and needs no clearing pass.
module sobel_gradient_stream #(
  parameter int MAX_SIZE = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: image_size
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sgs_pkg::CFG_W-1:0]      cfg_data,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // [7:0] height
  input  logic [0:0]                     in_tuser,  // [0] command
  // result items
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sgs_pkg::OUT_DATA_W-1:0] out_tdata, // [10:0] gradient_x, [21:11] gradient_y,
                                                    // [32:22] column, [43:33] row, rest zero
  output logic                           out_tlast  // last_of_frame
);
  import sgs_pkg::*;

  logic      a_valid;
  logic      a_ready;
  sgs_win_t  a_win;
  sgs_meta_t a_meta;
  sgs_cmd_t  in_cmd;

  // Size writes must come only while idle; the block does not enforce this and always takes them.
  assign cfg_ready = 1'b1;
  assign in_cmd    = sgs_cmd_t'(in_tuser[0]);

  sgs_window_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_window_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_cmd),
    .in_height (in_tdata),
    .a_valid   (a_valid),
    .a_ready   (a_ready),
    .a_win     (a_win),
    .a_meta    (a_meta)
  );

  sgs_gradient u_gradient (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_valid   (a_valid),
    .a_ready   (a_ready),
    .a_win     (a_win),
    .a_meta    (a_meta),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== verif/sobel_gradient_stream_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sobel_gradient_stream: drives pixel and flush items,
// predicts every gradient result in place and compares it on the result stream.
// Depends on sgs_pkg and the sobel_gradient_stream RTL only.
module sobel_gradient_stream_tb;
  import sgs_pkg::*;

  localparam int       HALF_NS      = 6;
  localparam int       MAX_SIDE     = 2048;
  localparam int       CENTRE_W     = 2;
  localparam int       SETTLE       = 8;
  localparam int       TAIL         = 16;
  localparam int       RANDOM_ITEMS = 200;
  localparam int       CALM_ITEMS   = 100;
  localparam int       CLAMP_ITEMS  = 5;
  localparam int       HOLD_LONG    = 400;
  localparam longint   LIMIT_NS     = 64'd10_000_000;
  localparam sgs_pix_t PIX_MAX      = 8'hFF;
  localparam sgs_pix_t PIX_MIN      = 8'h00;
  localparam int       GX_LSB       = 0;
  localparam int       GY_LSB       = 11;
  localparam int       COL_LSB      = 22;
  localparam int       ROW_LSB      = 33;
  localparam int       PAD_LSB      = 44;

  typedef struct {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [POS_W-1:0]         column;
    logic [POS_W-1:0]         row;
    logic                     last;
  } gradient_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] height
  logic [0:0]            in_tuser;   // [0] command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [10:0] gx, [21:11] gy, [32:22] column, [43:33] row
  logic                  out_tlast;  // last_of_frame

  // pacing knobs shared by the sender, the sink and the tests
  bit          calm         = 1'b0;
  int unsigned src_gap_pct  = 0;
  int unsigned sink_gap_pct = 0;
  int unsigned hold_cycles  = 0;

  int unsigned fails         = 0;
  int unsigned grads_checked = 0;
  int unsigned items_used    = 0;
  int unsigned frames_done   = 0;
  int unsigned cfg_writes    = 0;

  // predicted block state
  sgs_pix_t    line_older [MAX_SIDE];
  sgs_pix_t    line_newer [MAX_SIDE];
  sgs_win_t    win;
  int unsigned col_in;
  int unsigned row_in;
  int unsigned pos_out;
  int unsigned size_reg;
  gradient_t   grads_due [$];

  sobel_gradient_stream #(.MAX_SIZE(MAX_SIDE)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned active_side();
    if (size_reg < SIZE_FLOOR) return SIZE_FLOOR;
    if (size_reg > MAX_SIDE) return MAX_SIDE;
    return size_reg;
  endfunction

  function automatic void restart_frame();
    col_in  = 0;
    row_in  = 0;
    pos_out = 0;
    win     = '0;
  endfunction

  function automatic void shift_window(sgs_pix_t top, sgs_pix_t mid, sgs_pix_t bot);
    win[0] = win[1];
    win[1] = win[2];
    win[2] = {bot, mid, top};
  endfunction

  function automatic gradient_t window_gradients(int unsigned n);
    sgs_win_t    k;
    int unsigned orow;
    int unsigned ocol;
    int          gx;
    int          gy;
    int          c;
    gradient_t   g;
    k    = win;
    orow = pos_out / n;
    ocol = pos_out % n;
    // replace missing neighbors at the borders by the centre column / row
    if (ocol == 0) k[0] = k[1];
    if (ocol == n - 1) k[2] = k[1];
    for (c = 0; c < 3; c++) begin
      if (orow == 0) k[c][0] = k[c][1];
      if (orow == n - 1) k[c][2] = k[c][1];
    end
    gx = (int'(k[0][0]) + CENTRE_W * int'(k[0][1]) + int'(k[0][2]))
       - (int'(k[2][0]) + CENTRE_W * int'(k[2][1]) + int'(k[2][2]));
    gy = (int'(k[0][0]) + CENTRE_W * int'(k[1][0]) + int'(k[2][0]))
       - (int'(k[0][2]) + CENTRE_W * int'(k[1][2]) + int'(k[2][2]));
    g.gx     = GRAD_W'(gx);
    g.gy     = GRAD_W'(gy);
    g.column = POS_W'(ocol);
    g.row    = POS_W'(orow);
    g.last   = (pos_out == n * n - 1);
    return g;
  endfunction

  // Returns 0 for an item that the block drops.
  function automatic bit advance_sobel(sgs_cmd_t cmd, sgs_pix_t height);
    int unsigned n;
    int unsigned ic;
    sgs_pix_t    o;
    sgs_pix_t    w;
    bit          ready;
    bit          last;
    n = active_side();
    if (row_in < n) begin
      if (cmd == CMD_FLUSH) return 1'b0;
      ic = (col_in >= n) ? n - 1 : col_in;
      o  = line_older[ic];
      w  = line_newer[ic];
      shift_window(o, w, height);
      line_older[ic] = w;
      line_newer[ic] = height;
      ready  = (row_in >= 2) || (row_in == 1 && ic >= 1);
      col_in = ic + 1;
      if (col_in >= n) begin
        col_in = 0;
        row_in++;
      end
      if (ready) begin
        grads_due.push_back(window_gradients(n));
        pos_out++;
      end
      return 1'b1;
    end
    // draining: every item acts as a flush tick
    if (col_in < n) shift_window(line_older[col_in], line_newer[col_in], PIX_MIN);
    else shift_window(PIX_MIN, PIX_MIN, PIX_MIN);
    grads_due.push_back(window_gradients(n));
    last = (pos_out >= n * n - 1);
    pos_out++;
    col_in++;
    if (last) restart_frame();
    return 1'b1;
  endfunction

  function automatic void compare_field(string name, logic signed [15:0] want,
                                        logic signed [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // ------------------------------------------------------------ scoreboard

  always @(posedge clk) begin : scoreboard
    gradient_t want;
    int        i;
    if (!rst_n) begin
      for (i = 0; i < MAX_SIDE; i++) begin
        line_older[i] = PIX_MIN;
        line_newer[i] = PIX_MIN;
      end
      size_reg = RESET_SIZE;
      restart_frame();
      grads_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
        restart_frame();
      end
      if (in_tvalid && in_tready) begin
        if (advance_sobel(sgs_cmd_t'(in_tuser[0]), in_tdata)) items_used++;
      end
      if (out_tvalid && out_tready) begin
        if (grads_due.size() == 0) begin
          $error("result with none expected: column %0d row %0d",
                 out_tdata[COL_LSB +: POS_W], out_tdata[ROW_LSB +: POS_W]);
          fails++;
        end else begin
          want = grads_due.pop_front();
          compare_field("gradient_x", want.gx, $signed(out_tdata[GX_LSB +: GRAD_W]));
          compare_field("gradient_y", want.gy, $signed(out_tdata[GY_LSB +: GRAD_W]));
          compare_field("column", want.column, out_tdata[COL_LSB +: POS_W]);
          compare_field("row", want.row, out_tdata[ROW_LSB +: POS_W]);
          compare_field("last_of_frame", want.last, out_tlast);
          compare_field("pad", 0, out_tdata[OUT_DATA_W-1:PAD_LSB]);
          grads_checked++;
          if (want.last) frames_done++;
        end
      end
    end
  end

  // ------------------------------------------------------- result side pacing

  initial begin : sink_pacing
    int unsigned stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < sink_gap_pct) stall = $urandom_range(1, 12);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(sgs_cmd_t cmd, sgs_pix_t height);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < src_gap_pct) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= height;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic park_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Let every expected result out, then give a dropped item time to clear.
  task automatic wait_drained();
    park_input();
    while (grads_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_pixels(int unsigned count, bit extremes, int unsigned noise_pct);
    int unsigned i;
    sgs_pix_t    h;
    for (i = 0; i < count; i++) begin
      // a flush before the frame is complete is dropped
      if ($urandom_range(0, 99) < noise_pct) send_item(CMD_FLUSH, sgs_pix_t'($urandom));
      h = extremes ? ($urandom_range(0, 1) ? PIX_MAX : PIX_MIN) : sgs_pix_t'($urandom);
      send_item(CMD_PIXEL, h);
    end
  endtask

  task automatic send_drain(int unsigned n);
    int unsigned i;
    for (i = 0; i <= n; i++)
      send_item($urandom_range(0, 1) ? CMD_FLUSH : CMD_PIXEL, sgs_pix_t'($urandom));
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return CFG_W'($urandom_range(0, SIZE_FLOOR - 1));
    if (roll < 3) return CFG_W'($urandom_range(11, 24));
    return CFG_W'($urandom_range(SIZE_FLOOR, 10));
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 40;
    endcase
  endfunction

  // ------------------------------------------------------------------ tests

  // Run at the reset size: a dropped flush, then row 0 and the start of row 1.
  task automatic test_reset_size();
    src_gap_pct  = 10;
    sink_gap_pct = 10;
    send_item(CMD_FLUSH, PIX_MAX);
    send_pixels(RESET_SIZE + 8, 1'b0, 0);
    wait_drained();
  endtask

  // Smallest frames with full-scale gradients, early flush and drain cases.
  task automatic test_small_frames();
    int unsigned r;
    int unsigned c;
    write_size('0);
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        send_item(CMD_PIXEL, (c == 0) ? PIX_MAX : PIX_MIN);
    // a pixel during the drain counts as a flush tick
    send_item(CMD_PIXEL, PIX_MAX);
    repeat (3) send_item(CMD_FLUSH, PIX_MIN);
    write_size(CFG_W'(SIZE_FLOOR - 1));
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++) begin
        if (r == 1 && c == 0) send_item(CMD_FLUSH, PIX_MAX);
        send_item(CMD_PIXEL, (r == 2) ? PIX_MAX : PIX_MIN);
      end
    repeat (4) send_item(CMD_FLUSH, PIX_MIN);
    wait_drained();
  endtask

  // Largest size written directly, then an oversize value; a short start of
  // row 0 must give no result at either size.
  task automatic test_size_clamp();
    write_size(CFG_W'(MAX_SIDE));
    send_pixels(CLAMP_ITEMS, 1'b0, 0);
    write_size('1);
    send_pixels(CLAMP_ITEMS, 1'b0, 0);
    wait_drained();
  endtask

  // Long sink hold while the source keeps offering, then a source pause mid-frame.
  task automatic test_backpressure();
    write_size(12'd20);
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    hold_cycles  = HOLD_LONG;
    send_pixels(200, 1'b0, 0);
    wait_drained();
    send_pixels(200, 1'b0, 0);
    send_drain(20);
    wait_drained();
  endtask

  task automatic test_random_frames(int unsigned item_goal);
    int unsigned start;
    int unsigned n;
    bit          must_write;
    start      = items_used;
    must_write = 1'b1;
    while (items_used - start < item_goal) begin
      if (must_write || $urandom_range(0, 3) == 0) write_size(pick_size());
      must_write   = 1'b0;
      n            = active_side();
      src_gap_pct  = pick_pct();
      sink_gap_pct = pick_pct();
      if ($urandom_range(0, 6) == 0) begin
        // abort the frame part way; the next size write restarts it
        send_pixels($urandom_range(1, n * n - 1), 1'b0, 3);
        must_write = 1'b1;
      end else begin
        send_pixels(n * n, $urandom_range(0, 4) == 0, 3);
        send_drain(n);
        if ($urandom_range(0, 5) == 0) send_item(CMD_FLUSH, sgs_pix_t'($urandom));
      end
    end
  endtask

  initial begin : main_sequence
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_size();
    test_small_frames();
    test_size_clamp();
    test_backpressure();
    test_random_frames(RANDOM_ITEMS);
    calm = 1'b1;
    test_random_frames(CALM_ITEMS);

    park_input();
    while (grads_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    $display("run covered %0d items, %0d gradients checked, %0d frames closed, %0d size writes",
             items_used, grads_checked, frames_done, cfg_writes);
    $display("sizes from clamped-low to the largest, drain ticks, dropped flushes, stalls");
    if (fails == 0 && grads_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
design/sgs_pkg.sv
design/sgs_line_buffer.sv
design/sgs_window_ctrl.sv
design/sgs_gradient.sv
design/sobel_gradient_stream.sv
verif/sobel_gradient_stream_tb.sv
